FILE: design/sorted_group_sum_count_unit_macros.svh
// Assertion helpers shared by the aggregation unit and its result queue.
`ifndef SORTED_GROUP_SUM_COUNT_UNIT_MACROS_SVH
`define SORTED_GROUP_SUM_COUNT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SGSC_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SGSC_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

FILE: design/sgsc_pkg.sv
package sgsc_pkg;

   // Configuration port
   localparam int CSR_WIDTH = 3;
   localparam logic CSR_COLUMNS   = 1'b0;
   localparam logic CSR_ROW_FLAGS = 1'b1;
   localparam logic [CSR_WIDTH-1:0] COLUMNS_RESET = 3'd4;

   // Result queue
   localparam int QUEUE_DEPTH = 4;

   // Up to two results are written into the queue per request
   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } sgsc_push_type;

endpackage

FILE: design/sorted_group_sum_count_unit.sv
// A result is registered in the result queue when the request that closes its group is accepted.
// Throughput: one request per cycle while req_tready is high; a request emits zero, one or two results.
// req_tready drops while fewer than two of the four result queue slots are free.
// Reset (synchronous, active high) closes any open group, empties the result queue,
// and sets columns_in_use to 4 and use_row_flags to 0.
module sorted_group_sum_count_unit #(
   parameter int VALUE_COLUMNS = 4,
   parameter int VALUE_WIDTH   = 32,
   parameter int KEY_WIDTH     = 64,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic clock,
   input  logic reset,
   // request: group_key, value_0 .. value_N (low to high)
   input  logic                                                    req_tvalid,
   output logic                                                    req_tready,
   input  logic [((KEY_WIDTH + VALUE_COLUMNS*VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                                    req_tuser,  // row_active
   input  logic                                                    req_tlast,  // last_row
   // result: out_key, sum_0 .. sum_N, row_count (low to high)
   output logic                                                    rsp_tvalid,
   input  logic                                                    rsp_tready,
   output logic [((KEY_WIDTH + VALUE_COLUMNS*VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8 - 1:0]
                                                                   rsp_tdata,
   output logic                                                    rsp_tuser,  // group_active
   output logic                                                    rsp_tlast,  // final_group
   // configuration writes
   input  logic                                                    csr_wen,
   input  logic                                                    csr_index,
   input  logic [sgsc_pkg::CSR_WIDTH-1:0]                          csr_wdata
);
   import sgsc_pkg::*;
`include "sorted_group_sum_count_unit_macros.svh"

   localparam int SUM_BASE    = KEY_WIDTH;
   localparam int COUNT_BASE  = KEY_WIDTH + VALUE_COLUMNS * VALUE_WIDTH;
   localparam int OUT_BITS    = COUNT_BASE + COUNT_WIDTH;
   localparam int ACTIVE_BIT  = OUT_BITS;
   localparam int FINAL_BIT   = OUT_BITS + 1;
   localparam int RES_W       = OUT_BITS + 2;
   localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
   localparam int COL_IDX_W   = CSR_WIDTH + 1;

   // Configuration registers
   logic [CSR_WIDTH-1:0] cols_ff;
   logic                 flags_ff;

   // Open group state
   logic                   open_ff, open_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] sum_ff [VALUE_COLUMNS];
   logic [VALUE_WIDTH-1:0] sum_in [VALUE_COLUMNS];
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   act_ff, act_in;

   logic                     accept;
   logic [KEY_WIDTH-1:0]     in_key;
   logic                     row_act;
   logic                     key_change;
   logic                     new_group;
   logic [VALUE_COLUMNS-1:0] col_en;
   logic [RES_W-1:0]         res_close, res_last;
   logic [RES_W-1:0]         first_data;
   logic [RES_W-1:0]         q_data;
   logic                     q_room;
   sgsc_push_type            push;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLUMNS_RESET;
         flags_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_COLUMNS:   cols_ff  <= csr_wdata;
            CSR_ROW_FLAGS: flags_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Decode the request
   assign accept     = req_tvalid && req_tready;
   assign req_tready = q_room;
   assign in_key     = req_tdata[KEY_WIDTH-1:0];
   assign row_act    = flags_ff ? req_tuser : 1'b1;
   assign key_change = open_ff && (in_key != key_ff);
   assign new_group  = !open_ff || key_change;

   // Fold the row into the group it belongs to
   for (genvar c = 0; c < VALUE_COLUMNS; c++) begin : g_col
      assign col_en[c] = (COL_IDX_W'(c) < {1'b0, cols_ff});
      assign sum_in[c] = (new_group ? '0 : sum_ff[c])
                       + (col_en[c] ? req_tdata[SUM_BASE + c*VALUE_WIDTH +: VALUE_WIDTH] : '0);
   end

   assign key_in   = new_group ? in_key : key_ff;
   assign act_in   = new_group ? row_act : act_ff;
   assign count_in = new_group ? COUNT_WIDTH'(1)
                   : ((count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1));
   assign open_in  = !req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (accept) begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff   <= key_in;
         count_ff <= count_in;
         act_ff   <= act_in;
         for (int c = 0; c < VALUE_COLUMNS; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
   end

   // Build the closing result of the old group and the one for a last row
   always_comb begin
      res_close = '0;
      res_last  = '0;
      res_close[KEY_WIDTH-1:0] = act_ff ? key_ff : '0;
      res_last[KEY_WIDTH-1:0]  = act_in ? key_in : '0;
      for (int c = 0; c < VALUE_COLUMNS; c++) begin
         res_close[SUM_BASE + c*VALUE_WIDTH +: VALUE_WIDTH] =
            (act_ff && col_en[c]) ? sum_ff[c] : '0;
         res_last[SUM_BASE + c*VALUE_WIDTH +: VALUE_WIDTH] =
            (act_in && col_en[c]) ? sum_in[c] : '0;
      end
      res_close[COUNT_BASE +: COUNT_WIDTH] = act_ff ? count_ff : '0;
      res_last[COUNT_BASE +: COUNT_WIDTH]  = act_in ? count_in : '0;
      res_close[ACTIVE_BIT] = act_ff;
      res_last[ACTIVE_BIT]  = act_in;
      res_close[FINAL_BIT]  = 1'b0;
      res_last[FINAL_BIT]   = 1'b1;
   end

   // Push results in order: closed group first, then the last-row group
   assign push.first_valid  = accept && (key_change || req_tlast);
   assign push.second_valid = accept && key_change && req_tlast;
   assign first_data        = key_change ? res_close : res_last;

   sgsc_result_queue #(
      .DATA_WIDTH (RES_W)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .first_data  (first_data),
      .second_data (res_last),
      .has_room    (q_room),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (q_data)
   );

   assign rsp_tdata = OUT_TDATA_W'(q_data[OUT_BITS-1:0]);
   assign rsp_tuser = q_data[ACTIVE_BIT];
   assign rsp_tlast = q_data[FINAL_BIT];

   `SGSC_ASSERT_NEXT(a_last_closes_group, clock, reset, accept && req_tlast, !open_ff)
   `SGSC_ASSERT_NOW(a_key_change_pushes, clock, reset, accept && key_change, push.first_valid)
   `SGSC_ASSERT_NEXT(a_accept_opens_group, clock, reset, accept && !req_tlast, open_ff)

endmodule

FILE: design/sgsc_result_queue.sv
module sgsc_result_queue #(
   parameter int DATA_WIDTH = 226
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sgsc_pkg::sgsc_push_type push,
   input  logic [DATA_WIDTH-1:0]   first_data,
   input  logic [DATA_WIDTH-1:0]   second_data,
   output logic                    has_room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [DATA_WIDTH-1:0]   out_data
);
   import sgsc_pkg::*;
`include "sorted_group_sum_count_unit_macros.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      push_cnt;
   logic                  pop;

   // Occupancy and pointer update
   assign push_cnt  = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign count_in  = count_ff + push_cnt - CNT_W'(pop);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign has_room  = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign out_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed results; the second one goes behind the first
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         slot_ff[wr_ptr_ff] <= first_data;
      end
      if (push.second_valid) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= second_data;
      end
   end

   `SGSC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SGSC_ASSERT_NOW(a_second_needs_first, clock, reset, push.second_valid, push.first_valid)
   `SGSC_ASSERT_NEXT(a_count_tracks, clock, reset, !push.first_valid && !pop,
                     count_ff == $past(count_ff))

endmodule
